[design/vmt_pkg.sv]
// Types and constants shared by the vertex matrix transform unit.
`default_nettype none

package vmt_pkg;

   localparam int NUM_COMPS       = 4;
   localparam int NUM_REGS        = 8;
   localparam int VERT_WIDTH      = 32;
   localparam int COEF_WIDTH      = 32;
   localparam int PROD_WIDTH      = VERT_WIDTH + COEF_WIDTH;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 2 * COEF_WIDTH;
   localparam int PIPE_DEPTH      = 5;

   typedef struct packed {
      logic signed [VERT_WIDTH-1:0] in_x;
      logic signed [VERT_WIDTH-1:0] in_y;
      logic signed [VERT_WIDTH-1:0] in_z;
      logic signed [VERT_WIDTH-1:0] in_w;
   } req_type;

   typedef struct packed {
      logic signed [VERT_WIDTH-1:0] out_x;
      logic signed [VERT_WIDTH-1:0] out_y;
      logic signed [VERT_WIDTH-1:0] out_z;
      logic signed [VERT_WIDTH-1:0] out_w;
      logic                         saturated;
   } rsp_type;

   typedef struct packed {
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  data;
   } csr_type;

endpackage

`default_nettype wire

[design/vmt_if.sv]
// Valid/ready channel interfaces for vertex items, result items and register writes.
`default_nettype none

interface vmt_req_if import vmt_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface vmt_rsp_if import vmt_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface vmt_csr_if import vmt_pkg::*; ();
   logic    valid;
   logic    ready;
   csr_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[design/vertex_matrix_transform_unit.sv]
// A vertex taken on req reaches rsp through the five register stages listed below.
// Throughput: one vertex per cycle through five register stages (input, 16 products,
// pair sums, column sums, shift and clamp); a rsp stall holds stages up to a bubble.
// Reset: clears all stage valid bits and loads the identity matrix into the coefficients.
// Register writes are taken in every cycle.
`default_nettype none

module vertex_matrix_transform_unit import vmt_pkg::*; #(
   parameter int FRAC_BITS  = 16,
   parameter int COMP_WIDTH = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   vmt_req_if.sink   req,
   vmt_rsp_if.source rsp,
   vmt_csr_if.sink   csr
);

   localparam int PAIR_WIDTH = PROD_WIDTH + 1;
   localparam int SUM_WIDTH  = PROD_WIDTH + 2;
   localparam int Q_WIDTH    = SUM_WIDTH - FRAC_BITS;
   localparam logic [COEF_WIDTH-1:0] ONE = COEF_WIDTH'(1) << FRAC_BITS;
   localparam logic signed [COMP_WIDTH-1:0] MAX_VAL = {1'b0, {(COMP_WIDTH-1){1'b1}}};
   localparam logic signed [COMP_WIDTH-1:0] MIN_VAL = {1'b1, {(COMP_WIDTH-1){1'b0}}};

   logic [CSR_DATA_WIDTH-1:0] coef_ff [NUM_REGS];

   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;
   logic [PIPE_DEPTH-1:0] adv;

   logic signed [VERT_WIDTH-1:0] vert_ff [NUM_COMPS];
   logic signed [VERT_WIDTH-1:0] vert_in [NUM_COMPS];
   logic signed [COEF_WIDTH-1:0] coef_m  [NUM_COMPS][NUM_COMPS];
   logic signed [PROD_WIDTH-1:0] prod_ff [NUM_COMPS][NUM_COMPS];
   logic signed [PROD_WIDTH-1:0] prod_in [NUM_COMPS][NUM_COMPS];
   logic signed [PAIR_WIDTH-1:0] pair_ff [NUM_COMPS][2];
   logic signed [PAIR_WIDTH-1:0] pair_in [NUM_COMPS][2];
   logic signed [SUM_WIDTH-1:0]  sum_ff  [NUM_COMPS];
   logic signed [SUM_WIDTH-1:0]  sum_in  [NUM_COMPS];
   logic signed [VERT_WIDTH-1:0] res_in  [NUM_COMPS];
   logic                         sat_in;
   rsp_type                      rsp_ff;
   rsp_type                      rsp_in;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            if ((r & 1) == ((r >> 1) >> 1)) begin
               coef_ff[r] <= CSR_DATA_WIDTH'(ONE) << (((r >> 1) & 1) * COEF_WIDTH);
            end else begin
               coef_ff[r] <= '0;
            end
         end
      end else if (csr.valid && (csr.payload.index < CSR_INDEX_WIDTH'(NUM_REGS))) begin
         coef_ff[csr.payload.index[$clog2(NUM_REGS)-1:0]] <= csr.payload.data;
      end
   end

   assign csr.ready = 1'b1;

   // stage advance: a stage loads when empty or when the next one moves on
   always_comb begin
      adv[PIPE_DEPTH-1] = !valid_ff[PIPE_DEPTH-1] || rsp.ready;
      for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = req.valid;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign req.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_comb begin
      vert_in[0] = req.payload.in_x;
      vert_in[1] = req.payload.in_y;
      vert_in[2] = req.payload.in_z;
      vert_in[3] = req.payload.in_w;
      for (int i = 0; i < NUM_COMPS; i++) begin
         for (int j = 0; j < NUM_COMPS; j++) begin
            coef_m[i][j]  = coef_ff[2 * i + j / 2][(j % 2) * COEF_WIDTH +: COEF_WIDTH];
            prod_in[i][j] = vert_ff[i] * coef_m[i][j];
         end
      end
      for (int j = 0; j < NUM_COMPS; j++) begin
         pair_in[j][0] = PAIR_WIDTH'(prod_ff[0][j]) + PAIR_WIDTH'(prod_ff[1][j]);
         pair_in[j][1] = PAIR_WIDTH'(prod_ff[2][j]) + PAIR_WIDTH'(prod_ff[3][j]);
         sum_in[j]     = SUM_WIDTH'(pair_ff[j][0]) + SUM_WIDTH'(pair_ff[j][1]);
      end
   end

   // floor shift, then clamp to the component range
   always_comb begin
      logic signed [Q_WIDTH-1:0]    q;
      logic [Q_WIDTH-COMP_WIDTH:0]  hi;
      logic signed [COMP_WIDTH-1:0] val;
      q      = '0;
      hi     = '0;
      val    = '0;
      sat_in = 1'b0;
      for (int j = 0; j < NUM_COMPS; j++) begin
         q  = sum_ff[j][SUM_WIDTH-1:FRAC_BITS];
         hi = q[Q_WIDTH-1:COMP_WIDTH-1];
         if ((&hi) || !(|hi)) begin
            val = q[COMP_WIDTH-1:0];
         end else begin
            val    = q[Q_WIDTH-1] ? MIN_VAL : MAX_VAL;
            sat_in = 1'b1;
         end
         res_in[j] = VERT_WIDTH'(val);
      end
      rsp_in.out_x     = res_in[0];
      rsp_in.out_y     = res_in[1];
      rsp_in.out_z     = res_in[2];
      rsp_in.out_w     = res_in[3];
      rsp_in.saturated = sat_in;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         vert_ff <= vert_in;
      end
      if (adv[1]) begin
         prod_ff <= prod_in;
      end
      if (adv[2]) begin
         pair_ff <= pair_in;
      end
      if (adv[3]) begin
         sum_ff <= sum_in;
      end
      if (adv[4]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid   = valid_ff[PIPE_DEPTH-1];
   assign rsp.payload = rsp_ff;

endmodule

`default_nettype wire

[design/vmt_checker.sv]
// Port-level checks on the vertex matrix transform unit and their binding.
`default_nettype none

module vmt_checker import vmt_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_payload
);

   localparam int CNT_WIDTH = $clog2(PIPE_DEPTH + 1);

   logic [CNT_WIDTH-1:0] open_ff;
   logic [CNT_WIDTH-1:0] open_in;

   always_comb begin
      open_in = open_ff + CNT_WIDTH'(req_valid && req_ready)
              - CNT_WIDTH'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_empty_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result item shown right after reset");

   a_no_invented_item : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (open_ff != '0))
      else $error("result item without an accepted vertex");

   a_bounded_occupancy : assert property (@(posedge clock) disable iff (reset)
      open_ff <= CNT_WIDTH'(PIPE_DEPTH))
      else $error("more vertices in flight than pipeline stages");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result item changed or dropped");

endmodule

bind vertex_matrix_transform_unit vmt_checker u_vmt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);

`default_nettype wire
